>>> design/sdt_pkg.sv
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types, widths and constants for the sigmoid neuron trainer.
// ----------------------------------------------------------------------------
package sdt_pkg;

  localparam int FEAT_W      = 16;
  localparam int WEIGHT_W    = 32;
  localparam int ACT_W       = 16;
  localparam int RATE_W      = 16;
  localparam int APB_W       = 32;
  localparam int ADDR_W      = 3;
  localparam int REG_IDX_W   = ADDR_W - 2;

  // lane product w * x, signed Q24.24
  localparam int PROD_W      = WEIGHT_W + FEAT_W + 1;
  // |z| below 8.0 in Q24.24
  localparam int ZMAG_W      = 27;
  // rate * |err|, then times g
  localparam int ERR_W       = ACT_W + 1;
  localparam int P1_W        = RATE_W + ERR_W;
  localparam int G_W         = ACT_W;
  localparam int P2_W        = P1_W + G_W;
  // step magnitude Q8.56 and rounded step Q8.16
  localparam int MAG_W       = 64;
  localparam int STEP_SHIFT  = 40;
  localparam int STEP_W      = MAG_W - STEP_SHIFT;
  localparam logic [MAG_W-1:0] ROUND_HALF = MAG_W'(64'h80_0000_0000);

  localparam logic [RATE_W-1:0]          RATE_RESET   = 16'd6554;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET = 32'sd32768;
  localparam logic [ACT_W-1:0]           ACT_HALF     = 16'd32768;

  localparam logic [REG_IDX_W-1:0] REG_LEARNING_RATE = '0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_ABS,
    S_IDX,
    S_LOOK,
    S_GRAD,
    S_SCALE,
    S_STEP,
    S_UPD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic scale;
    logic update;
    logic err_neg;
  } lane_ctrl_t;

  typedef struct packed {
    logic acc;
    logic mag;
    logic index;
    logic look;
  } merge_ctrl_t;

  // e^-t in Q0.32 for t in Q16.16; elaboration-time table build only
  function automatic logic [63:0] exp_neg_q32(input logic [63:0] t_q16);
    logic [63:0] one;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] a3;
    logic [63:0] a4;
    logic [63:0] e;
    one = 64'd1 << 32;
    a   = t_q16 << 8;
    a2  = (a * a) >> 32;
    a3  = (a2 * a) >> 32;
    a4  = (a3 * a) >> 32;
    e   = one - a + a2 / 64'd2 - a3 / 64'd6 + a4 / 64'd24;
    if (e > 64'hFFFF_FFFF) begin
      e = 64'hFFFF_FFFF;
    end
    for (int s = 0; s < 8; s++) begin
      e = (e * e + (64'd1 << 31)) >> 32;
    end
    return e;
  endfunction

endpackage

>>> design/sdt_sample_if.sv
// ----------------------------------------------------------------------------
// sdt_sample_if
// Input channel: one sample per transaction.
// ----------------------------------------------------------------------------
interface sdt_sample_if;
  import sdt_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [FEAT_W-1:0] feature_a;
  logic [FEAT_W-1:0] feature_b;
  logic              target;

  modport source (output valid, kind, feature_a, feature_b, target, input ready);
  modport sink   (input valid, kind, feature_a, feature_b, target, output ready);
endinterface

>>> design/sdt_result_if.sv
// ----------------------------------------------------------------------------
// sdt_result_if
// Output channel: activation, decision and weights per transaction.
// ----------------------------------------------------------------------------
interface sdt_result_if;
  import sdt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACT_W-1:0]           activation;
  logic                       decision;
  logic signed [WEIGHT_W-1:0] weight_a_now;
  logic signed [WEIGHT_W-1:0] weight_b_now;

  modport source (output valid, activation, decision, weight_a_now, weight_b_now,
                  input ready);
  modport sink   (input valid, activation, decision, weight_a_now, weight_b_now,
                  output ready);
endinterface

>>> design/sdt_lane.sv
// ----------------------------------------------------------------------------
// sdt_lane
// One weight lane: holds a weight, forms w * x and applies the delta step.
// ----------------------------------------------------------------------------
module sdt_lane (
  input  logic                               clk,
  input  logic                               rst,
  input  sdt_pkg::lane_ctrl_t                ctrl,
  input  logic [sdt_pkg::FEAT_W-1:0]         feature,
  input  logic [sdt_pkg::P2_W-1:0]           scale,
  output logic signed [sdt_pkg::PROD_W-1:0]  prod,
  output logic signed [sdt_pkg::WEIGHT_W-1:0] weight
);
  import sdt_pkg::*;

  logic [FEAT_W-1:0]          x;
  logic [MAG_W-1:0]           mag;
  logic [MAG_W-1:0]           rounded;
  logic [STEP_W-1:0]          step_val;
  logic signed [WEIGHT_W+1:0] wide_w;
  logic signed [WEIGHT_W+1:0] wide_step;
  logic signed [WEIGHT_W+1:0] wide_new;
  logic signed [WEIGHT_W-1:0] weight_next;

  always_comb begin
    rounded   = mag + ROUND_HALF;
    step_val  = rounded[MAG_W-1:STEP_SHIFT];
    wide_w    = (WEIGHT_W+2)'(weight);
    wide_step = $signed({{(WEIGHT_W+2-STEP_W){1'b0}}, step_val});
    wide_new  = ctrl.err_neg ? wide_w - wide_step : wide_w + wide_step;
    if (wide_new[WEIGHT_W+1:WEIGHT_W-1] == 3'b000 ||
        wide_new[WEIGHT_W+1:WEIGHT_W-1] == 3'b111) begin
      weight_next = wide_new[WEIGHT_W-1:0];
    end else if (wide_new[WEIGHT_W+1]) begin
      weight_next = {1'b1, {(WEIGHT_W-1){1'b0}}};
    end else begin
      weight_next = {1'b0, {(WEIGHT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= WEIGHT_RESET;
    end else if (ctrl.update) begin
      weight <= weight_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x <= feature;
    end
    if (ctrl.mul) begin
      prod <= weight * $signed({1'b0, x});
    end
    if (ctrl.scale) begin
      mag <= MAG_W'(scale) * MAG_W'(x);
    end
  end

endmodule

>>> design/sdt_merge.sv
// ----------------------------------------------------------------------------
// sdt_merge
// Sums the lane products into z and maps z through the sigmoid table.
// ----------------------------------------------------------------------------
module sdt_merge #(
  parameter int INPUT_COUNT     = 2,
  parameter int SIGMOID_ENTRIES = 256
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  sdt_pkg::merge_ctrl_t                           ctrl,
  input  logic [INPUT_COUNT-1:0][sdt_pkg::PROD_W-1:0]    prods,
  output logic                                           sum_last,
  output logic [sdt_pkg::ACT_W-1:0]                      activation
);
  import sdt_pkg::*;

  localparam int SUM_W   = PROD_W + $clog2(INPUT_COUNT);
  localparam int CNT_W   = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
  localparam int IDX_W   = $clog2(SIGMOID_ENTRIES);
  localparam int ENT_W   = $clog2(SIGMOID_ENTRIES + 1);
  localparam int IPROD_W = ZMAG_W + ENT_W;

  logic [ACT_W-1:0]        sig_rom [SIGMOID_ENTRIES];

  logic [CNT_W-1:0]        cnt;
  logic signed [PROD_W-1:0] sel;
  logic signed [SUM_W-1:0] acc;
  logic [SUM_W-1:0]        abs_full;
  logic                    neg;
  logic                    sat;
  logic [ZMAG_W-1:0]       zmag;
  logic [IPROD_W-1:0]      iprod;
  logic [IDX_W-1:0]        idx;
  logic [ACT_W-1:0]        entry;
  logic [ACT_W:0]          flipped;

  for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_rom
    localparam logic [63:0] T   = (64'(k) * 64'd8 * 64'd65536) / 64'(SIGMOID_ENTRIES);
    localparam logic [63:0] DEN = (64'd1 << 32) + exp_neg_q32(T);
    localparam logic [63:0] V   = ((64'd1 << 48) + DEN / 64'd2) / DEN;
    assign sig_rom[k] = (V > 64'd65535) ? {ACT_W{1'b1}} : V[ACT_W-1:0];
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < INPUT_COUNT; i++) begin
      if (cnt == CNT_W'(i)) begin
        sel = prods[i];
      end
    end
    sum_last = (cnt == CNT_W'(INPUT_COUNT - 1));
    abs_full = acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
    iprod    = IPROD_W'(zmag) * IPROD_W'(SIGMOID_ENTRIES);
    entry    = sig_rom[idx];
    flipped  = {1'b1, {ACT_W{1'b0}}} - {1'b0, entry};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.acc) begin
      cnt <= sum_last ? '0 : cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc) begin
      acc <= (cnt == '0) ? SUM_W'(sel) : acc + SUM_W'(sel);
    end
    if (ctrl.mag) begin
      neg  <= acc[SUM_W-1];
      sat  <= |abs_full[SUM_W-1:ZMAG_W];
      zmag <= abs_full[ZMAG_W-1:0];
    end
    if (ctrl.index) begin
      idx <= sat ? IDX_W'(SIGMOID_ENTRIES - 1) : iprod[ZMAG_W +: IDX_W];
    end
    if (ctrl.look) begin
      activation <= neg ? flipped[ACT_W-1:0] : entry;
    end
  end

endmodule

>>> design/sigmoid_neuron_delta_trainer.sv
// ----------------------------------------------------------------------------
// sigmoid_neuron_delta_trainer
// Logistic neuron with table sigmoid and delta-rule weight training.
// ----------------------------------------------------------------------------
// Usage:
//   sample : valid/ready channel, one transaction per item (kind, two Q8.8
//            features, target). kind = 1 trains after classifying.
//   result : valid/ready channel, one transaction per item: Q0.16
//            activation, decision bit and both Q16.16 weights after the item.
//   APB    : learning_rate at byte address 0, written in the access phase.
// Flow: one item at a time. Sample ready is high only while idle. An item
//   is classified by lane multiply, INPUT_COUNT accumulate steps in the
//   merge adder, abs, index multiply, table read and output load; when
//   training, gradient, scale, lane step and weight update come before the
//   output load.
// Reset: weights return to 0.5, learning_rate to 6554, result channel empty.
// Stall: a finished item holds in the result register until taken; the next
//   item is still accepted and computed, then waits in the output state, and
//   no further sample is accepted until the result register frees.
// ----------------------------------------------------------------------------
module sigmoid_neuron_delta_trainer #(
  parameter int INPUT_COUNT     = 2,
  parameter int SIGMOID_ENTRIES = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  sdt_sample_if.sink                    sample,
  sdt_result_if.source                  result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sdt_pkg::ADDR_W-1:0]    paddr,
  input  logic [sdt_pkg::APB_W-1:0]     pwdata,
  output logic [sdt_pkg::APB_W-1:0]     prdata,
  output logic                          pready
);
  import sdt_pkg::*;

  state_t                            state;
  state_t                            state_next;
  lane_ctrl_t                        lane_ctrl;
  merge_ctrl_t                       merge_ctrl;

  logic [RATE_W-1:0]                 learning_rate;
  logic                              kind;
  logic                              target;
  logic                              err_neg;
  logic [P1_W-1:0]                   p1;
  logic [G_W-1:0]                    g;
  logic [P2_W-1:0]                   p2;

  logic [INPUT_COUNT-1:0][PROD_W-1:0] prods;
  logic [INPUT_COUNT-1:0][WEIGHT_W-1:0] weights;
  logic                              sum_last;
  logic [ACT_W-1:0]                  act;
  logic                              out_free;
  logic                              out_load;
  logic                              cfg_hit;

  logic [ERR_W-1:0]                  act_wide;
  logic [ERR_W-1:0]                  tgt_wide;
  logic                              err_neg_c;
  logic [ERR_W-1:0]                  err_mag_c;
  logic [ACT_W+ERR_W-1:0]            g_full;

  logic                              res_valid;
  logic [ACT_W-1:0]                  res_act;
  logic                              res_decision;
  logic signed [WEIGHT_W-1:0]        res_wa;
  logic signed [WEIGHT_W-1:0]        res_wb;
  logic signed [WEIGHT_W-1:0]        weight_b_src;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[ADDR_W-1:2] == REG_LEARNING_RATE);
  assign prdata  = cfg_hit ? APB_W'(learning_rate) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= RATE_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      learning_rate <= pwdata[RATE_W-1:0];
    end
  end

  // lanes
  for (genvar i = 0; i < INPUT_COUNT; i++) begin : g_lane
    logic [FEAT_W-1:0] feat;
    if (i == 0) begin : g_fa
      assign feat = sample.feature_a;
    end else if (i == 1) begin : g_fb
      assign feat = sample.feature_b;
    end else begin : g_fz
      assign feat = '0;
    end

    sdt_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (lane_ctrl),
      .feature (feat),
      .scale   (p2),
      .prod    (prods[i]),
      .weight  (weights[i])
    );
  end

  if (INPUT_COUNT > 1) begin : g_wb
    assign weight_b_src = weights[1];
  end else begin : g_nowb
    assign weight_b_src = '0;
  end

  sdt_merge #(
    .INPUT_COUNT     (INPUT_COUNT),
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (merge_ctrl),
    .prods      (prods),
    .sum_last   (sum_last),
    .activation (act)
  );

  // gradient terms
  always_comb begin
    act_wide  = {1'b0, act};
    tgt_wide  = target ? {1'b1, {ACT_W{1'b0}}} : '0;
    err_neg_c = act_wide > tgt_wide;
    err_mag_c = err_neg_c ? act_wide - tgt_wide : tgt_wide - act_wide;
    g_full    = (ACT_W+ERR_W)'(act) * (ACT_W+ERR_W)'({1'b1, {ACT_W{1'b0}}} - act_wide);
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      kind   <= sample.kind;
      target <= sample.target;
    end
    if (state == S_GRAD) begin
      err_neg <= err_neg_c;
      p1      <= P1_W'(learning_rate) * P1_W'(err_mag_c);
      g       <= g_full[ACT_W +: G_W];
    end
    if (state == S_SCALE) begin
      p2 <= P2_W'(p1) * P2_W'(g);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_free     = !res_valid || result.ready;
  assign sample.ready = (state == S_IDLE);

  always_comb begin
    state_next        = state;
    lane_ctrl         = '0;
    merge_ctrl        = '0;
    out_load          = 1'b0;
    lane_ctrl.err_neg = err_neg;
    unique case (state)
      S_IDLE: begin
        lane_ctrl.load = sample.valid;
        if (sample.valid) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        lane_ctrl.mul = 1'b1;
        state_next    = S_SUM;
      end
      S_SUM: begin
        merge_ctrl.acc = 1'b1;
        if (sum_last) begin
          state_next = S_ABS;
        end
      end
      S_ABS: begin
        merge_ctrl.mag = 1'b1;
        state_next     = S_IDX;
      end
      S_IDX: begin
        merge_ctrl.index = 1'b1;
        state_next       = S_LOOK;
      end
      S_LOOK: begin
        merge_ctrl.look = 1'b1;
        state_next      = kind ? S_GRAD : S_OUT;
      end
      S_GRAD: begin
        state_next = S_SCALE;
      end
      S_SCALE: begin
        state_next = S_STEP;
      end
      S_STEP: begin
        lane_ctrl.scale = 1'b1;
        state_next      = S_UPD;
      end
      S_UPD: begin
        lane_ctrl.update = 1'b1;
        state_next       = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_act      <= act;
      res_decision <= (act > ACT_HALF);
      res_wa       <= weights[0];
      res_wb       <= weight_b_src;
    end
  end

  assign result.valid        = res_valid;
  assign result.activation   = res_act;
  assign result.decision     = res_decision;
  assign result.weight_a_now = res_wa;
  assign result.weight_b_now = res_wb;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sigmoid neuron trainer. A predictor holds its
// own copy of the weights, learning rate and sigmoid table and computes the
// expected transaction for each accepted sample. Results are checked in
// order. Directed items cover the feature extremes, rate extremes, a small
// negative dot product and an unmapped register. Random streams then run
// under varied backpressure, including one long result stall.
// ----------------------------------------------------------------------------
module tb_top;
  import sdt_pkg::*;

  localparam int LUT_SIZE = 256;
  localparam int NUM_FEATS = 2;
  localparam logic signed [WEIGHT_W-1:0] W_INIT = 32'sd32768;
  localparam logic [RATE_W-1:0] RATE_INIT = 16'd6554;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 1'b1;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [ACT_W-1:0]           activation;
    logic                       decision;
    logic signed [WEIGHT_W-1:0] weight_a;
    logic signed [WEIGHT_W-1:0] weight_b;
  } neuron_out_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_W-1:0]  pwdata;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  sdt_sample_if smp ();
  sdt_result_if res ();

  sigmoid_neuron_delta_trainer u_top (
    .clk     (clk),
    .rst     (rst),
    .sample  (smp),
    .result  (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bit [ACT_W-1:0]             sig_lut [LUT_SIZE];
  logic signed [WEIGHT_W-1:0] model_w [NUM_FEATS];
  logic [RATE_W-1:0]          model_rate;
  neuron_out_t                neuron_outputs_due [$];
  neuron_out_t                oldest;
  int                         mismatches = 0;
  int                         send_gap_pct = 0;
  int                         recv_gap_pct = 0;
  int                         hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(64'd5_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // e^-t in Q0.32, t in Q16.16
  function automatic bit [63:0] decay_q32(input bit [63:0] t);
    bit [63:0] a;
    bit [63:0] a2;
    bit [63:0] a3;
    bit [63:0] a4;
    bit [63:0] e;
    a  = t << 8;
    a2 = (a * a) >> 32;
    a3 = (a2 * a) >> 32;
    a4 = (a3 * a) >> 32;
    e  = (64'd1 << 32) - a + a2 / 64'd2 - a3 / 64'd6 + a4 / 64'd24;
    if (e > 64'hFFFF_FFFF) begin
      e = 64'hFFFF_FFFF;
    end
    for (int s = 0; s < 8; s++) begin
      e = (e * e + (64'd1 << 31)) >> 32;
    end
    return e;
  endfunction

  function automatic void build_sigmoid_lut();
    bit [63:0] t;
    bit [63:0] den;
    bit [63:0] v;
    for (int k = 0; k < LUT_SIZE; k++) begin
      t   = (64'(k) * 64'd8 * 64'd65536) / 64'(LUT_SIZE);
      den = (64'd1 << 32) + decay_q32(t);
      v   = ((64'd1 << 48) + den / 64'd2) / den;
      if (v > 64'd65535) begin
        v = 64'd65535;
      end
      sig_lut[k] = v[15:0];
    end
  endfunction

  function automatic neuron_out_t neuron_predict(input logic kind,
                                                 input logic [FEAT_W-1:0] fa,
                                                 input logic [FEAT_W-1:0] fb,
                                                 input logic tgt);
    bit [FEAT_W-1:0] x [NUM_FEATS];
    longint    z;
    bit [63:0] zmag;
    int        idx;
    bit [63:0] act;
    bit [63:0] tgt_v;
    bit [63:0] err_mag;
    bit [63:0] g;
    bit [63:0] mag;
    bit [63:0] step;
    bit        err_neg;
    longint    nw;
    neuron_out_t o;
    x[0] = fa;
    x[1] = fb;
    z = 0;
    for (int i = 0; i < NUM_FEATS; i++) begin
      z += longint'(model_w[i]) * longint'({48'd0, x[i]});
    end
    zmag = (z < 0) ? 64'(-z) : 64'(z);
    if (zmag >= (64'd8 << 24)) begin
      idx = LUT_SIZE - 1;
    end else begin
      idx = int'((zmag * 64'(LUT_SIZE)) >> 27);
    end
    act = (z < 0) ? 64'd65536 - 64'(sig_lut[idx]) : 64'(sig_lut[idx]);
    if (kind) begin
      tgt_v   = tgt ? 64'd65536 : 64'd0;
      err_neg = act > tgt_v;
      err_mag = err_neg ? act - tgt_v : tgt_v - act;
      g       = (act * (64'd65536 - act)) >> 16;
      for (int i = 0; i < NUM_FEATS; i++) begin
        mag  = 64'(model_rate) * err_mag * g * 64'(x[i]);
        step = (mag + (64'd1 << 39)) >> 40;
        nw   = err_neg ? longint'(model_w[i]) - longint'(step)
                       : longint'(model_w[i]) + longint'(step);
        if (nw > 64'sd2147483647) begin
          nw = 64'sd2147483647;
        end
        if (nw < -64'sd2147483648) begin
          nw = -64'sd2147483648;
        end
        model_w[i] = nw[31:0];
      end
    end
    o.activation = act[15:0];
    o.decision   = act > 64'd32768;
    o.weight_a   = model_w[0];
    o.weight_b   = model_w[1];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && smp.valid && smp.ready) begin
      neuron_outputs_due.push_back(neuron_predict(smp.kind, smp.feature_a,
                                                  smp.feature_b, smp.target));
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      if (neuron_outputs_due.size() == 0) begin
        report_mismatch("unexpected result transaction", 0, 1);
      end else begin
        oldest = neuron_outputs_due.pop_front();
        if (res.activation !== oldest.activation) begin
          report_mismatch("activation", oldest.activation, res.activation);
        end
        if (res.decision !== oldest.decision) begin
          report_mismatch("decision", oldest.decision, res.decision);
        end
        if (res.weight_a_now !== oldest.weight_a) begin
          report_mismatch("weight_a_now", oldest.weight_a, res.weight_a_now);
        end
        if (res.weight_b_now !== oldest.weight_b) begin
          report_mismatch("weight_b_now", oldest.weight_b, res.weight_b_now);
        end
      end
    end
  end

  // result side: random stalls, or a long hold while hold_left counts down
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else begin
        res.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // valid stays high after the transaction; a gap in the next call or stop_samples lowers it
  task automatic send_sample(input logic kind, input logic [FEAT_W-1:0] fa,
                             input logic [FEAT_W-1:0] fb, input logic tgt);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      smp.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    smp.valid     <= 1'b1;
    smp.kind      <= kind;
    smp.feature_a <= fa;
    smp.feature_b <= fb;
    smp.target    <= tgt;
    do @(posedge clk); while (!smp.ready);
  endtask

  task automatic stop_samples();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (neuron_outputs_due.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LEARNING_RATE) begin
      model_rate = data[RATE_W-1:0];
    end
  endtask

  function automatic logic [FEAT_W-1:0] pick_feature();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2, 3: return FEAT_W'($urandom_range(1023));
      4: return FEAT_W'($urandom_range(255));
      default: return FEAT_W'($urandom);
    endcase
  endfunction

  task automatic test_reset_classify();
    send_sample(1'b0, 16'd0, 16'd0, 1'b0);
    send_sample(1'b0, 16'd256, 16'd256, 1'b1);
    stop_samples();
  endtask

  task automatic test_feature_extremes();
    send_sample(1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
    send_sample(1'b0, 16'hFFFF, 16'h0000, 1'b1);
    send_sample(1'b0, 16'h0000, 16'hFFFF, 1'b0);
    send_sample(1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
    send_sample(1'b1, 16'h0000, 16'h0000, 1'b0);
    stop_samples();
  endtask

  task automatic test_rate_extremes();
    apb_write(REG_LEARNING_RATE, 32'd0);
    send_sample(1'b1, 16'd512, 16'd300, 1'b0);
    send_sample(1'b1, 16'd100, 16'hFFFF, 1'b1);
    stop_samples();
    apb_write(REG_LEARNING_RATE, 32'd65535);
    send_sample(1'b1, 16'hFFFF, 16'd1, 1'b1);
    stop_samples();
  endtask

  // drive weight_a negative, then probe tiny negative dot products
  task automatic test_negative_drive();
    apb_write(REG_LEARNING_RATE, 32'd65535);
    for (int i = 0; i < 8; i++) begin
      send_sample(1'b1, 16'd256, 16'd0, 1'b0);
    end
    send_sample(1'b0, 16'd1, 16'd0, 1'b0);
    send_sample(1'b0, 16'd2, 16'd0, 1'b1);
    send_sample(1'b0, 16'd256, 16'd0, 1'b0);
    stop_samples();
  endtask

  task automatic test_unmapped_register();
    apb_write(REG_UNMAPPED, 32'd0);
    send_sample(1'b1, 16'd256, 16'd256, 1'b1);
    send_sample(1'b1, 16'd64, 16'd700, 1'b0);
    stop_samples();
    apb_write(REG_LEARNING_RATE, 32'(RATE_INIT));
  endtask

  task automatic test_result_backpressure();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_left = 300;
    for (int i = 0; i < 12; i++) begin
      send_sample(1'($urandom), pick_feature(), pick_feature(), 1'($urandom));
    end
    stop_samples();
  endtask

  task automatic test_random_stream(input int n, input int s_gap, input int r_gap,
                                    input logic [RATE_W-1:0] rate);
    apb_write(REG_LEARNING_RATE, 32'(rate));
    send_gap_pct = s_gap;
    recv_gap_pct = r_gap;
    for (int i = 0; i < n; i++) begin
      send_sample(($urandom_range(99) < 70), pick_feature(), pick_feature(),
                  1'($urandom));
    end
    stop_samples();
  endtask

  initial begin
    rst           <= 1'b1;
    smp.valid     <= 1'b0;
    smp.kind      <= 1'b0;
    smp.feature_a <= '0;
    smp.feature_b <= '0;
    smp.target    <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    build_sigmoid_lut();
    for (int i = 0; i < NUM_FEATS; i++) begin
      model_w[i] = W_INIT;
    end
    model_rate = RATE_INIT;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_gap_pct = 10;
    recv_gap_pct = 10;
    test_reset_classify();
    test_feature_extremes();
    test_rate_extremes();
    test_negative_drive();
    test_unmapped_register();
    test_result_backpressure();

    test_random_stream(380, 19, 48, 16'($urandom));
    test_random_stream(380, 48, 19, 16'd65535);
    test_random_stream(200, 0, 0, 16'd0);
    test_random_stream(190, 0, 0, 16'($urandom_range(8191)));

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
